// ===== rtl/periodic_task_fire_scheduler_core_assert.svh =====
// Assertion macros for the periodic task fire scheduler checker.
// Depends on nothing; included by the checker file only.
`ifndef PERIODIC_TASK_FIRE_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_TASK_FIRE_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfs check failed");

`endif

// ===== rtl/pfs_pkg.sv =====
// Shared types and constants for the periodic task fire scheduler.
// Used by the controller, the datapath, the top level and the checker.
package pfs_pkg;

    localparam int TIME_W = 31;
    localparam int FT_W   = 16;
    localparam int PER_W  = 16;
    localparam int SLOT_W = 4;
    localparam int LATE_W = 32;
    localparam int RATE_W = 9;
    localparam int AVG_W  = 16;
    localparam int PROD_W = AVG_W + RATE_W;
    localparam int SUM_W  = LATE_W + 3;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(26);
    localparam logic [RATE_W-1:0] RATE_ONE   = RATE_W'(256);

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_REG    = 2'd1,
        ACT_UNREG  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        POL_AFTER   = 2'd0,
        POL_BEFORE  = 2'd1,
        POL_CLOSEST = 2'd2,
        POL_AVERAGE = 2'd3
    } t_policy;

    typedef enum logic [1:0] {
        KIND_FIRED        = 2'd0,
        KIND_REGISTERED   = 2'd1,
        KIND_FULL         = 2'd2,
        KIND_UNREGISTERED = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_MUL,
        ST_AVG_UPD,
        ST_TICK_RD,
        ST_TICK_EVA,
        ST_TICK_EVB,
        ST_TICK_DEC,
        ST_TICK_FLUSH,
        ST_REG_SCAN,
        ST_UNREG
    } t_state;

    typedef struct packed {
        logic [PER_W-1:0]         period;
        t_policy                  policy;
        logic [TIME_W-1:0]        last_fire;
        logic signed [LATE_W-1:0] delay;
    } t_slot_row;

    typedef struct packed {
        logic cap_in;
        logic idx_clr;
        logic idx_inc;
        logic avg_mul;
        logic avg_upd;
        logic eval_a;
        logic eval_b;
        logic decide;
        logic flush;
        logic reg_wr;
        logic full_emit;
        logic unreg;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_valid;
        logic idx_last;
    } t_dp_stat;

endpackage

// ===== rtl/pfs_ctrl.sv =====
// Controller state machine of the periodic task fire scheduler.
// Depends on pfs_pkg; drives the datapath through a command struct.
module pfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_action,
    input  pfs_pkg::t_dp_stat i_stat,
    output logic              busy,
    output pfs_pkg::t_dp_cmd  o_cmd
);
    import pfs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.cap_in  = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    unique case (t_action'(i_action))
                        ACT_TICK:  n_state = ST_AVG_MUL;
                        ACT_REG:   n_state = ST_REG_SCAN;
                        ACT_UNREG: n_state = ST_UNREG;
                        ACT_NONE:  n_state = ST_IDLE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_AVG_MUL: begin
                o_cmd.avg_mul = 1'b1;
                n_state       = ST_AVG_UPD;
            end
            ST_AVG_UPD: begin
                o_cmd.avg_upd = 1'b1;
                n_state       = ST_TICK_RD;
            end
            ST_TICK_RD: begin
                // The slot row is being read this cycle; free slots are skipped.
                if (i_stat.idx_valid) begin
                    n_state = ST_TICK_EVA;
                end else if (i_stat.idx_last) begin
                    n_state = ST_TICK_FLUSH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_TICK_EVA: begin
                o_cmd.eval_a = 1'b1;
                n_state      = ST_TICK_EVB;
            end
            ST_TICK_EVB: begin
                o_cmd.eval_b = 1'b1;
                n_state      = ST_TICK_DEC;
            end
            ST_TICK_DEC: begin
                o_cmd.decide = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ST_TICK_FLUSH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_TICK_RD;
                end
            end
            ST_TICK_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_REG_SCAN: begin
                if (!i_stat.idx_valid) begin
                    o_cmd.reg_wr = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_stat.idx_last) begin
                    o_cmd.full_emit = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_UNREG: begin
                o_cmd.unreg = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/pfs_dp.sv =====
// Datapath of the periodic task fire scheduler: slot table memory, valid bits,
// frame time average, fire decision and result registers. Depends on pfs_pkg.
module pfs_dp #(
    parameter int SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pfs_pkg::t_dp_cmd                  i_cmd,
    input  logic [pfs_pkg::TIME_W-1:0]        i_now_time,
    input  logic [pfs_pkg::FT_W-1:0]          i_frame_time,
    input  logic [1:0]                        i_policy,
    input  logic [pfs_pkg::PER_W-1:0]         i_period,
    input  logic [pfs_pkg::SLOT_W-1:0]        i_slot,
    input  logic                              i_cfg_we,
    input  logic [pfs_pkg::RATE_W-1:0]        i_cfg_data,
    output pfs_pkg::t_dp_stat                 o_stat,
    output logic                              o_strobe,
    output logic [1:0]                        o_kind,
    output logic [pfs_pkg::SLOT_W-1:0]        o_task_slot,
    output logic [pfs_pkg::TIME_W-1:0]        o_elapsed,
    output logic signed [pfs_pkg::LATE_W-1:0] o_lateness,
    output logic                              o_last
);
    import pfs_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic signed [LATE_W-1:0] DELAY_MAX = {1'b0, {(LATE_W-1){1'b1}}};
    localparam logic signed [LATE_W-1:0] DELAY_MIN = {1'b1, {(LATE_W-1){1'b0}}};

    // Configuration and running state.
    logic [RATE_W-1:0] r_rate;
    logic [AVG_W-1:0]  r_avg;
    logic [PROD_W-1:0] r_prod;
    logic [SLOTS-1:0]  r_valid;
    logic [SW-1:0]     r_idx;

    // Captured input item.
    logic [TIME_W-1:0] r_in_now;
    logic [FT_W-1:0]   r_in_ft;
    t_policy           r_in_pol;
    logic [PER_W-1:0]  r_in_per;
    logic [SLOT_W-1:0] r_in_slot;

    // Slot table and its registered read port.
    t_slot_row mem [SLOTS];
    t_slot_row r_rd;

    // Evaluation pipeline.
    logic [TIME_W-1:0]        r_delta;
    logic signed [LATE_W:0]   r_late;
    logic signed [SUM_W-1:0]  r_a;
    logic signed [SUM_W-1:0]  r_b;

    // Held fire result, released once the next fire or the end of the walk is known.
    logic                     r_hold_v;
    logic [SW-1:0]            r_hold_slot;
    logic [TIME_W-1:0]        r_hold_elapsed;
    logic signed [LATE_W-1:0] r_hold_late;

    // Result registers.
    logic                     r_strobe;
    t_kind                    r_kind;
    logic [SLOT_W-1:0]        r_slot_out;
    logic [TIME_W-1:0]        r_elapsed;
    logic signed [LATE_W-1:0] r_lateness;
    logic                     r_last;

    logic [RATE_W-1:0]        rate_eff;
    logic [RATE_W-1:0]        rate_rest;
    logic [PROD_W-1:0]        avg_sum;
    logic [TIME_W-1:0]        delta;
    logic signed [LATE_W:0]   late;
    logic signed [SUM_W-1:0]  a_sum;
    logic signed [SUM_W-1:0]  delay_sel;
    logic [SUM_W-1:0]         mag_a;
    logic [SUM_W-1:0]         mag_b;
    logic                     fire;
    logic                     fits;
    logic signed [LATE_W-1:0] new_delay;
    logic                     mem_we;
    t_slot_row                mem_wdata;
    logic                     unreg_in_range;
    logic [SW-1:0]            unreg_idx;

    // Moving average of the frame time.
    assign rate_eff  = (r_rate > RATE_ONE) ? RATE_ONE : r_rate;
    assign rate_rest = RATE_ONE - rate_eff;
    assign avg_sum   = r_prod + PROD_W'(r_in_ft) * PROD_W'(rate_eff);

    // First evaluation step: elapsed time modulo 2^31 and lateness.
    assign delta = r_in_now - r_rd.last_fire;
    assign late  = $signed({2'b00, delta}) - $signed({{(LATE_W+1-PER_W){1'b0}}, r_rd.period});

    // Second step: the average policy compares lateness shifted by its delay.
    assign delay_sel = (r_rd.policy == POL_AVERAGE) ? SUM_W'(r_rd.delay) : '0;
    assign a_sum     = SUM_W'(r_late) + delay_sel;

    // Decision step.
    assign mag_a = r_a[SUM_W-1] ? SUM_W'(-r_a) : SUM_W'(r_a);
    assign mag_b = r_b[SUM_W-1] ? SUM_W'(-r_b) : SUM_W'(r_b);

    always_comb begin
        case (r_rd.policy)
            POL_AFTER:  fire = !r_late[LATE_W];
            POL_BEFORE: fire = !r_b[SUM_W-1] && (r_b != '0);
            default:    fire = !(mag_b < mag_a);
        endcase
    end

    assign fits      = (r_a[SUM_W-1:LATE_W-1] == '0) || (r_a[SUM_W-1:LATE_W-1] == '1);
    assign new_delay = fits ? r_a[LATE_W-1:0] : (r_a[SUM_W-1] ? DELAY_MIN : DELAY_MAX);

    assign mem_we = (i_cmd.decide && fire) || i_cmd.reg_wr;

    always_comb begin
        if (i_cmd.reg_wr) begin
            mem_wdata.period    = r_in_per;
            mem_wdata.policy    = r_in_pol;
            mem_wdata.last_fire = r_in_now;
            mem_wdata.delay     = '0;
        end else begin
            mem_wdata.period    = r_rd.period;
            mem_wdata.policy    = r_rd.policy;
            mem_wdata.last_fire = r_in_now;
            mem_wdata.delay     = (r_rd.policy == POL_AVERAGE) ? new_delay : r_rd.delay;
        end
    end

    assign unreg_in_range = ({{(32-SLOT_W){1'b0}}, r_in_slot} < 32'(SLOTS));
    assign unreg_idx      = SW'(r_in_slot);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= RATE_RESET;
            r_avg   <= '0;
            r_valid <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_data;
            end
            if (i_cmd.avg_upd) begin
                r_avg <= (r_avg == '0) ? r_in_ft : avg_sum[AVG_W+7:8];
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + SW'(1);
            end
            if (i_cmd.reg_wr) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.unreg && unreg_in_range) begin
                r_valid[unreg_idx] <= 1'b0;
            end
        end
    end

    // Input capture and evaluation registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_in_now  <= i_now_time;
            r_in_ft   <= i_frame_time;
            r_in_pol  <= t_policy'(i_policy);
            r_in_per  <= i_period;
            r_in_slot <= i_slot;
        end
        if (i_cmd.avg_mul) begin
            r_prod <= PROD_W'(r_avg) * PROD_W'(rate_rest);
        end
        if (i_cmd.eval_a) begin
            r_delta <= delta;
            r_late  <= late;
        end
        if (i_cmd.eval_b) begin
            r_a <= a_sum;
            r_b <= a_sum + SUM_W'(r_avg);
        end
    end

    // Slot table.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= mem_wdata;
        end
        r_rd <= mem[r_idx];
    end

    // Results: one per cycle at most; a fire result is held until the next fire or the flush sets its last flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (i_cmd.decide && fire) begin
                r_strobe <= r_hold_v;
                r_hold_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_strobe <= r_hold_v;
                r_hold_v <= 1'b0;
            end else begin
                r_strobe <= i_cmd.reg_wr || i_cmd.full_emit || i_cmd.unreg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && fire) begin
            r_hold_slot    <= r_idx;
            r_hold_elapsed <= r_delta;
            r_hold_late    <= r_late[LATE_W-1:0];
        end
        if ((i_cmd.decide && fire) || i_cmd.flush) begin
            r_kind     <= KIND_FIRED;
            r_slot_out <= SLOT_W'(r_hold_slot);
            r_elapsed  <= r_hold_elapsed;
            r_lateness <= r_hold_late;
            r_last     <= i_cmd.flush;
        end else if (i_cmd.reg_wr || i_cmd.full_emit || i_cmd.unreg) begin
            r_elapsed  <= '0;
            r_lateness <= '0;
            r_last     <= 1'b1;
            if (i_cmd.reg_wr) begin
                r_kind     <= KIND_REGISTERED;
                r_slot_out <= SLOT_W'(r_idx);
            end else if (i_cmd.full_emit) begin
                r_kind     <= KIND_FULL;
                r_slot_out <= '0;
            end else begin
                r_kind     <= KIND_UNREGISTERED;
                r_slot_out <= r_in_slot;
            end
        end
    end

    assign o_stat.idx_valid = r_valid[r_idx];
    assign o_stat.idx_last  = (r_idx == SW'(SLOTS - 1));

    assign o_strobe    = r_strobe;
    assign o_kind      = r_kind;
    assign o_task_slot = r_slot_out;
    assign o_elapsed   = r_elapsed;
    assign o_lateness  = r_lateness;
    assign o_last      = r_last;

endmodule

// ===== rtl/periodic_task_fire_scheduler_core.sv =====
// Periodic task fire scheduler, top level: controller plus datapath.
// Depends on pfs_pkg, pfs_ctrl and pfs_dp.
//
// Usage. An item is taken at a rising edge where start is high and busy is
// low; i_action selects tick, register, unregister or nothing. Each result is
// shown on the o_ ports for one cycle, flagged by o_strobe, and o_last marks
// the final beat caused by an item. The receiver cannot stall, so every result
// beat must be taken the cycle it appears.
// The average_rate register is written through i_cfg_valid / o_cfg_ready /
// i_cfg_data; o_cfg_ready is high whenever the block is idle.
// Flow. Register scans the valid bits one slot per cycle; its single result
// follows in the cycle after the scan ends. Unregister clears a valid bit.
// A tick first updates the frame time average (one multiply per cycle), then
// walks the table: free slots are passed over at the read step, and each
// occupied slot goes through memory read, elapsed and lateness, delay sum, and
// decision and write back; a flush step ends the walk. The registered table
// read and the two evaluation stages form these per-slot steps. A fire result
// is held until the next fire decision or the flush, since o_last is only known
// then. At reset the table is empty, the average is zero and the rate is 26.
module periodic_task_fire_scheduler_core #(
    parameter int SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_action,
    input  logic [pfs_pkg::TIME_W-1:0]        i_now_time,
    input  logic [pfs_pkg::FT_W-1:0]          i_frame_time,
    input  logic [1:0]                        i_policy,
    input  logic [pfs_pkg::PER_W-1:0]         i_period,
    input  logic [pfs_pkg::SLOT_W-1:0]        i_slot,
    output logic                              o_strobe,
    output logic [1:0]                        o_kind,
    output logic [pfs_pkg::SLOT_W-1:0]        o_task_slot,
    output logic [pfs_pkg::TIME_W-1:0]        o_elapsed,
    output logic signed [pfs_pkg::LATE_W-1:0] o_lateness,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pfs_pkg::RATE_W-1:0]        i_cfg_data
);
    import pfs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration is only taken while no item is in flight.
    assign o_cfg_ready = !busy;

    pfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (stat),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    pfs_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_now_time   (i_now_time),
        .i_frame_time (i_frame_time),
        .i_policy     (i_policy),
        .i_period     (i_period),
        .i_slot       (i_slot),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_stat       (stat),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_task_slot  (o_task_slot),
        .o_elapsed    (o_elapsed),
        .o_lateness   (o_lateness),
        .o_last       (o_last)
    );

endmodule

// ===== rtl/pfs_chk.sv =====
// Port-level checker for the periodic task fire scheduler, bound to the top level.
// Depends on pfs_pkg and periodic_task_fire_scheduler_core_assert.svh.
`include "periodic_task_fire_scheduler_core_assert.svh"

module pfs_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [1:0]                        i_action,
    input logic                              o_strobe,
    input logic [1:0]                        o_kind,
    input logic [pfs_pkg::SLOT_W-1:0]        o_task_slot,
    input logic [pfs_pkg::TIME_W-1:0]        o_elapsed,
    input logic signed [pfs_pkg::LATE_W-1:0] o_lateness,
    input logic                              o_last
);
    import pfs_pkg::*;

    logic signed [LATE_W:0] elapsed_s;
    logic signed [LATE_W:0] lateness_s;
    logic                   work_taken;
    logic                   fired_beat;
    logic                   other_beat;
    logic                   full_beat;
    logic                   full_clean;

    assign elapsed_s  = $signed({2'b00, o_elapsed});
    assign lateness_s = (LATE_W+1)'(o_lateness);
    assign work_taken = start && !busy && (i_action != ACT_NONE);
    assign fired_beat = o_strobe && (o_kind == KIND_FIRED);
    assign other_beat = o_strobe && (o_kind != KIND_FIRED);
    assign full_beat  = o_strobe && (o_kind == KIND_FULL);
    assign full_clean = (o_task_slot == '0) && (o_elapsed == '0) && (o_lateness == '0);

    // Any item other than a no-op makes the block busy in the next cycle.
    `PFS_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, work_taken, busy)

    // Register, full and unregister produce exactly one result each.
    `PFS_ASSERT_NOW(a_single_last, i_clk, i_rst_n, other_beat, o_last)

    // A full table reports slot zero and no timing.
    `PFS_ASSERT_NOW(a_full_fields, i_clk, i_rst_n, full_beat, full_clean)

    // Lateness is elapsed minus a non-negative period.
    `PFS_ASSERT_NOW(a_late_bound, i_clk, i_rst_n, fired_beat, lateness_s <= elapsed_s)

endmodule

bind periodic_task_fire_scheduler_core pfs_chk u_pfs_chk (.*);

// ===== dv/pfs_sched_sb_pkg.sv =====
// Scoreboard for the periodic task fire scheduler: a predictor of the slot table,
// the frame time average and the rate register, plus the queue of result beats due.
// Depends on pfs_pkg for widths, enums and the rate constants.
package pfs_sched_sb_pkg;
    import pfs_pkg::*;

    localparam int     TABLE_SLOTS = 16;
    localparam longint LATE_MAX    = 2147483647;
    localparam longint LATE_MIN    = -LATE_MAX - 1;

    typedef struct packed {
        logic [1:0]               kind;
        logic [SLOT_W-1:0]        task_slot;
        logic [TIME_W-1:0]        elapsed;
        logic signed [LATE_W-1:0] lateness;
        logic                     last;
    } t_sched_beat;

    class fire_scoreboard;
        bit                       slot_busy     [TABLE_SLOTS];
        logic [PER_W-1:0]         slot_period   [TABLE_SLOTS];
        t_policy                  slot_policy   [TABLE_SLOTS];
        logic [TIME_W-1:0]        slot_fired_at [TABLE_SLOTS];
        logic signed [LATE_W-1:0] slot_delay    [TABLE_SLOTS];
        logic [AVG_W-1:0]         frame_avg;
        logic [RATE_W-1:0]        rate;
        t_sched_beat              due_beats [$];
        int                       mismatches;
        int                       beats_seen;

        function new();
            foreach (slot_busy[i]) slot_busy[i] = 1'b0;
            frame_avg  = '0;
            rate       = RATE_RESET;
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function void set_rate(logic [RATE_W-1:0] value);
            rate = value;
        endfunction

        static function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function t_sched_beat make_beat(t_kind k, logic [SLOT_W-1:0] s,
                                        logic [TIME_W-1:0] e, logic signed [LATE_W-1:0] l);
            t_sched_beat b;
            b.kind      = k;
            b.task_slot = s;
            b.elapsed   = e;
            b.lateness  = l;
            b.last      = 1'b0;
            return b;
        endfunction

        // Works out every beat one accepted item causes and queues them in order.
        function void predict_item(logic [1:0] act, logic [TIME_W-1:0] now,
                                   logic [FT_W-1:0] ft, logic [1:0] pol,
                                   logic [PER_W-1:0] per, logic [SLOT_W-1:0] sl);
            t_sched_beat       beats [$];
            int unsigned       weight;
            int unsigned       blend;
            logic [TIME_W-1:0] delta;
            longint            late_now;
            longint            late_next;
            longint            acc;
            bit                fire;
            int                free_slot;
            int                i;
            case (t_action'(act))
                ACT_TICK: begin
                    if (rate > RATE_ONE) weight = RATE_ONE;
                    else weight = rate;
                    if (frame_avg == '0) begin
                        frame_avg = ft;
                    end else begin
                        blend     = frame_avg * (RATE_ONE - weight) + ft * weight;
                        frame_avg = AVG_W'(blend >> 8);
                    end
                    for (i = 0; i < TABLE_SLOTS; i++) begin
                        if (!slot_busy[i]) continue;
                        // Elapsed time wraps at 31 bits, so time going back reads large.
                        delta     = now - slot_fired_at[i];
                        late_now  = longint'(delta) - longint'(slot_period[i]);
                        late_next = late_now + longint'(frame_avg);
                        acc       = slot_delay[i];
                        case (slot_policy[i])
                            POL_AFTER:   fire = (late_now >= 0);
                            POL_BEFORE:  fire = (late_next > 0);
                            POL_CLOSEST: fire = !(magnitude(late_next) < magnitude(late_now));
                            default:
                                fire = !(magnitude(late_next + acc) < magnitude(late_now + acc));
                        endcase
                        if (!fire) continue;
                        if (slot_policy[i] == POL_AVERAGE) begin
                            acc = acc + late_now;
                            if (acc > LATE_MAX) acc = LATE_MAX;
                            if (acc < LATE_MIN) acc = LATE_MIN;
                            slot_delay[i] = acc[LATE_W-1:0];
                        end
                        slot_fired_at[i] = now;
                        beats.push_back(make_beat(KIND_FIRED, SLOT_W'(i), delta,
                                                  late_now[LATE_W-1:0]));
                    end
                end
                ACT_REG: begin
                    free_slot = -1;
                    for (i = 0; i < TABLE_SLOTS; i++) begin
                        if (!slot_busy[i]) begin
                            free_slot = i;
                            break;
                        end
                    end
                    if (free_slot < 0) begin
                        beats.push_back(make_beat(KIND_FULL, '0, '0, '0));
                    end else begin
                        slot_busy[free_slot]     = 1'b1;
                        slot_period[free_slot]   = per;
                        slot_policy[free_slot]   = t_policy'(pol);
                        slot_fired_at[free_slot] = now;
                        slot_delay[free_slot]    = '0;
                        beats.push_back(make_beat(KIND_REGISTERED, SLOT_W'(free_slot), '0, '0));
                    end
                end
                ACT_UNREG: begin
                    slot_busy[sl] = 1'b0;
                    beats.push_back(make_beat(KIND_UNREGISTERED, sl, '0, '0));
                end
                default: ;
            endcase
            if (beats.size() > 0) beats[beats.size() - 1].last = 1'b1;
            foreach (beats[k]) due_beats.push_back(beats[k]);
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH: %s", what);
        endtask

        task check_beat(t_sched_beat got);
            t_sched_beat want;
            beats_seen++;
            if (due_beats.size() == 0) begin
                report($sformatf("beat %0d arrived with nothing due: kind %0d slot %0d",
                                 beats_seen, got.kind, got.task_slot));
                return;
            end
            want = due_beats.pop_front();
            if (got !== want)
                report($sformatf({"beat %0d got kind %0d slot %0d elapsed %0d late %0d last %0b,",
                                  " want kind %0d slot %0d elapsed %0d late %0d last %0b"},
                                 beats_seen, got.kind, got.task_slot, got.elapsed,
                                 got.lateness, got.last, want.kind, want.task_slot,
                                 want.elapsed, want.lateness, want.last));
        endtask
    endclass

endpackage

// ===== dv/tb.sv =====
// Top-level testbench for periodic_task_fire_scheduler_core: stimulus, config writes,
// the result monitor and the stall watchdog. Depends on pfs_pkg and pfs_sched_sb_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfs_pkg::*;
    import pfs_sched_sb_pkg::*;

    // A full tick walks 16 occupied slots after the averaging steps and ends
    // with a flush; the settle pause covers that.
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_GAP       = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 13;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  i_action;
    logic [TIME_W-1:0]           i_now_time;
    logic [FT_W-1:0]             i_frame_time;
    logic [1:0]                  i_policy;
    logic [PER_W-1:0]            i_period;
    logic [SLOT_W-1:0]           i_slot;
    logic                        o_strobe;
    logic [1:0]                  o_kind;
    logic [SLOT_W-1:0]           o_task_slot;
    logic [TIME_W-1:0]           o_elapsed;
    logic signed [LATE_W-1:0]    o_lateness;
    logic                        o_last;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [RATE_W-1:0]           i_cfg_data;

    fire_scoreboard              sched_sb;
    int                          quiet_cycles = 0;
    // Running notion of wall time used to build well-formed tick sequences.
    logic [TIME_W-1:0]           sim_now;

    periodic_task_fire_scheduler_core #(
        .SLOTS(TABLE_SLOTS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_now_time   (i_now_time),
        .i_frame_time (i_frame_time),
        .i_policy     (i_policy),
        .i_period     (i_period),
        .i_slot       (i_slot),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_task_slot  (o_task_slot),
        .o_elapsed    (o_elapsed),
        .o_lateness   (o_lateness),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Everything is sampled at the rising edge. A result beat is checked before
    // a new item is noted, since the last beat of one item may share an edge
    // with the acceptance of the next, never the other way round.
    // The watchdog counts edges where no beat, config write or item moved.
    always @(posedge i_clk) begin : monitor
        bit          moved;
        t_sched_beat seen;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_strobe) begin
                seen.kind      = o_kind;
                seen.task_slot = o_task_slot;
                seen.elapsed   = o_elapsed;
                seen.lateness  = o_lateness;
                seen.last      = o_last;
                sched_sb.check_beat(seen);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sched_sb.set_rate(i_cfg_data);
                moved = 1'b1;
            end
            if (start && !busy) begin
                sched_sb.predict_item(i_action, i_now_time, i_frame_time, i_policy,
                                      i_period, i_slot);
                moved = 1'b1;
            end
            if (moved) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("periodic_task_fire_scheduler_core verification failed");
                $finish;
            end
        end
    end

    // Presents one item from the falling edge and holds it until the block
    // takes it. Start is left high so a following item can go back to back.
    task automatic drive_item(input logic [1:0] act, input logic [TIME_W-1:0] now,
                              input logic [FT_W-1:0] ft, input logic [1:0] pol,
                              input logic [PER_W-1:0] per, input logic [SLOT_W-1:0] sl);
        @(negedge i_clk);
        i_action     = act;
        i_now_time   = now;
        i_frame_time = ft;
        i_policy     = pol;
        i_period     = per;
        i_slot       = sl;
        start        = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Stops sending and waits until every due beat has come. With settle set
    // it also waits out a tick that fires nothing, so the block is truly idle.
    task automatic drain(input bit settle);
        @(negedge i_clk);
        start = 1'b0;
        while (sched_sb.due_beats.size() != 0) @(negedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One random item. Most are well-formed: ticks that move time forward by
    // their frame time, and registrations at the current time. A few jump time
    // anywhere (often backwards), use extreme frame times or do nothing.
    // Fields the action ignores still carry random values.
    task automatic random_item();
        int unsigned       pick;
        int unsigned       roll;
        logic [1:0]        act;
        logic [TIME_W-1:0] now;
        logic [FT_W-1:0]   ft;
        logic [1:0]        pol;
        logic [PER_W-1:0]  per;
        logic [SLOT_W-1:0] sl;
        pick = $urandom_range(99);
        now  = TIME_W'($urandom);
        ft   = FT_W'($urandom);
        pol  = 2'($urandom);
        per  = PER_W'($urandom);
        sl   = SLOT_W'($urandom);
        if (pick < 45) begin
            act  = ACT_TICK;
            roll = $urandom_range(99);
            if (roll < 85) ft = FT_W'($urandom_range(1, 40));
            else if (roll < 90) ft = '0;
            sim_now = sim_now + ft;
            if ($urandom_range(99) < 5) sim_now = TIME_W'($urandom);
            now = sim_now;
        end else if (pick < 72) begin
            act = ACT_REG;
            if ($urandom_range(99) < 85) per = PER_W'($urandom_range(0, 120));
            if ($urandom_range(99) < 95) now = sim_now;
        end else if (pick < 95) begin
            act = ACT_UNREG;
        end else begin
            act = ACT_NONE;
        end
        drive_item(act, now, ft, pol, per, sl);
    endtask

    // A run of random items with the sender idle on idle_pct percent of the
    // cycles, and now and then a full pause until all results are back.
    task automatic run_phase(input int count, input int idle_pct);
        int gap;
        for (int n = 0; n < count; n++) begin
            gap = 0;
            while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < MAX_GAP) begin
                @(negedge i_clk);
                start = 1'b0;
                gap++;
            end
            if ($urandom_range(19) == 0) drain(1'b0);
            random_item();
        end
    endtask

    initial begin : stimulus
        logic [RATE_W-1:0] rates [6];
        int                idle_pcts [6];
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_action     = ACT_NONE;
        i_now_time   = '0;
        i_frame_time = '0;
        i_policy     = POL_AFTER;
        i_period     = '0;
        i_slot       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        sim_now      = '0;
        sched_sb     = new();
        rates        = '{RATE_ONE, RATE_W'(0), '1, RATE_W'($urandom), RATE_W'(1), RATE_RESET};
        idle_pcts    = '{0, 84, 0, 31, 84, 0};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, at the reset rate. An empty tick with a zero frame
        // time, unregistering a free slot, and an item that does nothing.
        drive_item(ACT_TICK, '0, '0, POL_AFTER, '0, '0);
        drive_item(ACT_UNREG, '0, '0, POL_AFTER, '0, 4'd15);
        drive_item(ACT_NONE, '1, '1, POL_AVERAGE, '1, '1);
        // One task of each policy, the first two with extreme periods and start times.
        drive_item(ACT_REG, '0, '0, POL_AFTER, '0, '0);
        drive_item(ACT_REG, '1, '0, POL_BEFORE, '1, '0);
        drive_item(ACT_REG, TIME_W'(1000), '0, POL_CLOSEST, PER_W'(100), '0);
        drive_item(ACT_REG, TIME_W'(1000), '0, POL_AVERAGE, PER_W'(50), '0);
        // The largest frame time seeds the average, then time runs backwards and
        // jumps to its largest value so the averaging task's delay climbs and saturates.
        drive_item(ACT_TICK, TIME_W'(1000), '1, POL_AFTER, '0, '0);
        drive_item(ACT_TICK, TIME_W'(500), FT_W'(16), POL_AFTER, '0, '0);
        drive_item(ACT_TICK, '1, '0, POL_AFTER, '0, '0);
        // Fill the table, then register once more to hit the full case.
        for (int k = 0; k < TABLE_SLOTS - 4; k++)
            drive_item(ACT_REG, TIME_W'(2000 + k), '0, 2'(k), PER_W'(10 * k), '0);
        drive_item(ACT_REG, TIME_W'(2050), '0, POL_AFTER, PER_W'(5), '0);
        drive_item(ACT_TICK, TIME_W'(2100), FT_W'(30), POL_AFTER, '0, '0);
        drive_item(ACT_UNREG, '0, '0, POL_AFTER, '0, '0);
        sim_now = TIME_W'(2100);

        // Random phases, each at its own rate and sender idling; the rate is
        // only written once the block has gone quiet.
        for (int p = 0; p < 6; p++) begin
            drain(1'b1);
            write_rate(rates[p]);
            run_phase(PHASE_ITEMS, idle_pcts[p]);
        end
        drain(1'b1);

        if (sched_sb.mismatches == 0)
            $display("periodic_task_fire_scheduler_core verification clean");
        else
            $display("periodic_task_fire_scheduler_core verification failed");
        $finish;
    end

endmodule
